### src/pdad_pkg.sv
// shared constants, types and event codes for the presence detector
// no dependencies

package pdad_pkg;

  localparam int WINDOW_DEPTH  = 100;
  localparam int SAMPLE_BITS   = 12;
  localparam int IDX_BITS      = $clog2(WINDOW_DEPTH);
  localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
  localparam int THR_BITS      = 12;
  localparam int SUM_BITS      = 19;
  localparam int TIME_BITS     = 32;
  localparam int PARK_S_BITS   = 12;
  localparam int MS_PER_S      = 1000;
  localparam int PARK_MS_BITS  = 22;
  localparam int INTERVAL_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARK_TIME = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUMMY     = 2'd2;

  localparam logic [THR_BITS-1:0]      THRESHOLD_RESET = 12'd50;
  localparam logic [PARK_MS_BITS-1:0]  PARK_MS_RESET   = 22'd5000;
  localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET  = 16'd0;

  typedef enum logic [1:0] {
    EV_NONE        = 2'd0,
    EV_DWELL_START = 2'd1,
    EV_PARKED      = 2'd2,
    EV_UNPARKED    = 2'd3
  } event_t;

  typedef struct packed {
    logic                  valid;
    logic                  dummy;
    logic [TIME_BITS-1:0]  now;
    logic [SUM_BITS-1:0]   sum;
    logic [CNT_BITS-1:0]   count;
    logic [SUM_BITS-1:0]   thr_cnt;
  } win_res_t;

endpackage

### src/presence_detector_avg_dwell.sv
// top level of the parking presence detector
// depends on pdad_pkg, pdad_window and pdad_presence

// Takes one item per clock and gives one result per item. At the edge that accepts an
// item the old sample at its write slot is fetched from the 100-entry sample memory and
// the item is registered; the update stage (running sum, threshold test, dwell timer)
// then works on it and loads the output register, from which the result is offered,
// when the output can advance. Throughput is set by the single read and single write
// port of the sample memory, each used at most once per item; the input stalls only while a
// result waits on the output. The sample memory is not cleared after reset; an entry's
// old value is only used once the ring is full. Configuration writes are taken at any
// time.

module presence_detector_avg_dwell (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // distance_cm, now_ms, zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // parked, event_res, window_sum, sample_count, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pdad_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pdad_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import pdad_pkg::*;

  logic [THR_BITS-1:0]      threshold;
  logic [PARK_MS_BITS-1:0]  park_ms;
  logic [INTERVAL_BITS-1:0] interval;

  logic                     adv;
  logic                     take;
  win_res_t                 res;
  logic                     parked;
  event_t                   ev;

  logic                     out_valid;
  logic                     out_parked;
  event_t                   out_ev;
  logic [SUM_BITS-1:0]      out_sum;
  logic [CNT_BITS-1:0]      out_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      park_ms   <= PARK_MS_RESET;
      interval  <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data[THR_BITS-1:0];
        CFG_PARK_TIME: park_ms   <= PARK_MS_BITS'(cfg_data[PARK_S_BITS-1:0] * MS_PER_S);
        CFG_DUMMY:     interval  <= cfg_data[INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign take          = s_axis_tvalid && adv;

  pdad_window u_window (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .adv         (adv),
    .distance_cm (s_axis_tdata[11:0]),
    .now_ms      (s_axis_tdata[43:12]),
    .dummy_mode  (interval != '0),
    .threshold   (threshold),
    .res         (res)
  );

  pdad_presence u_presence (
    .clk      (clk),
    .rst      (rst),
    .fire     (res.valid && adv),
    .res      (res),
    .park_ms  (park_ms),
    .interval (interval),
    .parked   (parked),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_parked <= parked;
      out_ev     <= ev;
      out_sum    <= res.sum;
      out_count  <= res.count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_sum, out_ev, out_parked};

endmodule

### src/pdad_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module pdad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/pdad_window.sv
// sample ring, fill count and running sum over the held samples
// depends on pdad_pkg and pdad_ram

module pdad_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            adv,
  input  logic [pdad_pkg::SAMPLE_BITS-1:0] distance_cm,
  input  logic [pdad_pkg::TIME_BITS-1:0]   now_ms,
  input  logic                            dummy_mode,
  input  logic [pdad_pkg::THR_BITS-1:0]    threshold,
  output pdad_pkg::win_res_t               res
);
  import pdad_pkg::*;

  logic [IDX_BITS-1:0]    write_index;
  logic [CNT_BITS-1:0]    held_count;
  logic [SUM_BITS-1:0]    running_sum;
  logic [SUM_BITS-1:0]    sum_next;
  logic                   full0;
  logic [CNT_BITS-1:0]    cnt_new;

  logic                   p1_valid;
  logic                   p1_dummy;
  logic [IDX_BITS-1:0]    p1_idx;
  logic                   p1_full;
  logic [SAMPLE_BITS-1:0] p1_sample;
  logic [TIME_BITS-1:0]   p1_now;
  logic [CNT_BITS-1:0]    p1_count;
  logic [SUM_BITS-1:0]    p1_thr_cnt;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic                   fire;

  assign full0   = held_count >= CNT_BITS'(WINDOW_DEPTH);
  assign cnt_new = full0 ? held_count : held_count + CNT_BITS'(1);
  assign fire    = p1_valid && adv;

  pdad_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (fire && !p1_dummy),
    .wr_addr (p1_idx),
    .wr_data (p1_sample),
    .rd_en   (take && !dummy_mode),
    .rd_addr (write_index),
    .rd_data (old_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      held_count  <= '0;
    end else if (take && !dummy_mode) begin
      held_count <= cnt_new;
      if (write_index == IDX_BITS'(WINDOW_DEPTH - 1)) begin
        write_index <= '0;
      end else begin
        write_index <= write_index + IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_dummy   <= dummy_mode;
      p1_idx     <= write_index;
      p1_full    <= full0;
      p1_sample  <= distance_cm;
      p1_now     <= now_ms;
      p1_count   <= dummy_mode ? held_count : cnt_new;
      p1_thr_cnt <= SUM_BITS'(threshold) * SUM_BITS'(cnt_new);
    end
  end

  assign sum_next = running_sum - (p1_full ? SUM_BITS'(old_sample) : '0)
                    + SUM_BITS'(p1_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (fire && !p1_dummy) begin
      running_sum <= sum_next;
    end
  end

  always_comb begin
    res.valid   = p1_valid;
    res.dummy   = p1_dummy;
    res.now     = p1_now;
    res.sum     = p1_dummy ? running_sum : sum_next;
    res.count   = p1_count;
    res.thr_cnt = p1_thr_cnt;
  end

endmodule

### src/pdad_presence.sv
// dwell timer, presence flag and test-mode toggling
// depends on pdad_pkg

module pdad_presence (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  pdad_pkg::win_res_t                res,
  input  logic [pdad_pkg::PARK_MS_BITS-1:0]  park_ms,
  input  logic [pdad_pkg::INTERVAL_BITS-1:0] interval,
  output logic                              parked,
  output pdad_pkg::event_t                  ev
);
  import pdad_pkg::*;

  logic                 presence_flag;
  logic                 dwell_active;
  logic [TIME_BITS-1:0] dwell_start_ms;
  logic                 toggle_started;
  logic [TIME_BITS-1:0] toggle_start_ms;

  logic                 presence_flag_next;
  logic                 dwell_active_next;
  logic [TIME_BITS-1:0] dwell_start_ms_next;
  logic [TIME_BITS-1:0] toggle_start_ms_next;
  logic [TIME_BITS-1:0] toggle_base;
  logic                 empty;
  event_t               ev_next;

  assign empty       = res.sum > res.thr_cnt;
  assign toggle_base = toggle_started ? toggle_start_ms : res.now;

  always_comb begin
    presence_flag_next   = presence_flag;
    dwell_active_next    = dwell_active;
    dwell_start_ms_next  = dwell_start_ms;
    toggle_start_ms_next = toggle_start_ms;
    ev_next              = EV_NONE;
    if (res.dummy) begin
      toggle_start_ms_next = toggle_base;
      if ((res.now - toggle_base) > TIME_BITS'(interval)) begin
        presence_flag_next   = !presence_flag;
        toggle_start_ms_next = res.now;
        ev_next              = EV_UNPARKED;
      end
    end else begin
      if (empty) begin
        if (presence_flag || dwell_active) begin
          presence_flag_next  = 1'b0;
          dwell_active_next   = 1'b0;
          dwell_start_ms_next = '0;
          ev_next             = EV_UNPARKED;
        end
      end else if (!dwell_active) begin
        dwell_active_next   = 1'b1;
        dwell_start_ms_next = res.now;
        ev_next             = EV_DWELL_START;
      end
      if (dwell_active_next && !presence_flag_next &&
          (res.now - dwell_start_ms_next) >= TIME_BITS'(park_ms)) begin
        presence_flag_next = 1'b1;
        ev_next            = EV_PARKED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_flag   <= 1'b0;
      dwell_active    <= 1'b0;
      dwell_start_ms  <= '0;
      toggle_started  <= 1'b0;
      toggle_start_ms <= '0;
    end else if (fire) begin
      presence_flag   <= presence_flag_next;
      dwell_active    <= dwell_active_next;
      dwell_start_ms  <= dwell_start_ms_next;
      toggle_start_ms <= toggle_start_ms_next;
      if (res.dummy) begin
        toggle_started <= 1'b1;
      end
    end
  end

  assign parked = presence_flag_next;
  assign ev     = ev_next;

endmodule
